// ===== design/fts_pkg.sv =====
package fts_pkg;

	localparam int REQ_W  = 3;
	localparam int TASK_W = 4;
	localparam int SLOT_W = 4;
	localparam int CRIT_W = 2;

	// request codes
	localparam logic [REQ_W-1:0] REQ_SLOT_WRITE = 3'd0;
	localparam logic [REQ_W-1:0] REQ_SET_READY  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_UNPAUSE    = 3'd2;
	localparam logic [REQ_W-1:0] REQ_SET_CRIT   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_DEQUEUE    = 3'd4;
	localparam logic [REQ_W-1:0] REQ_POP        = 3'd5;
	localparam logic [REQ_W-1:0] REQ_PREEMPT_Q  = 3'd6;

	// slot table write command
	typedef struct packed {
		logic              en;
		logic              occupied;
		logic [TASK_W-1:0] task_id;
	} slot_wr_t;

	// task table update command
	typedef struct packed {
		logic              set_ready;
		logic              ready_value;
		logic              set_crit;
		logic [CRIT_W-1:0] crit;
		logic [TASK_W-1:0] task_id;
	} task_cmd_t;

endpackage

// ===== design/fts_slot_mem.sv =====
module fts_slot_mem
	import fts_pkg::*;
#(
	parameter int NUM_SLOTS = 16,
	parameter int SIW       = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  slot_wr_t          wr,
	input  logic [SIW-1:0]    wr_addr,
	input  logic              clr_en,
	input  logic [SIW-1:0]    clr_addr,
	input  logic              rd_en,
	input  logic [SIW-1:0]    rd_addr,
	output logic              rd_valid,
	output logic [TASK_W-1:0] rd_task
);

	logic [TASK_W-1:0]    mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] valid_q;
	logic                 rd_valid_q;
	logic [TASK_W-1:0]    rd_task_q;

	// task field only matters while the slot is valid
	always_ff @(posedge clk) begin
		if (wr.en && wr.occupied) begin
			mem[wr_addr] <= wr.task_id;
		end
		if (rd_en) begin
			rd_task_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr_addr] <= wr.occupied;
			end else if (clr_en) begin
				valid_q[clr_addr] <= 1'b0;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_valid = rd_valid_q;
	assign rd_task  = rd_task_q;

endmodule

// ===== design/fts_task_tbl.sv =====
module fts_task_tbl
	import fts_pkg::*;
#(
	parameter int NUM_TASKS  = 16,
	parameter int NUM_LEVELS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  task_cmd_t         cmd,
	input  logic [TASK_W-1:0] lk_task,
	output logic              lk_ready,
	output logic [CRIT_W-1:0] lk_crit
);

	localparam int TIW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

	logic [NUM_TASKS-1:0] ready_q;
	logic [CRIT_W-1:0]    crit_q [NUM_TASKS];
	logic                 cmd_ok;
	logic                 lk_ok;
	logic [CRIT_W-1:0]    crit_sat;

	assign cmd_ok = 32'(cmd.task_id) < NUM_TASKS;
	assign lk_ok  = 32'(lk_task) < NUM_TASKS;

	// clamp to the top level
	assign crit_sat = (32'(cmd.crit) >= NUM_LEVELS) ? CRIT_W'(NUM_LEVELS - 1) : cmd.crit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= '0;
			for (int i = 0; i < NUM_TASKS; i++) begin
				crit_q[i] <= '0;
			end
		end else if (cmd_ok) begin
			if (cmd.set_ready) begin
				ready_q[TIW'(cmd.task_id)] <= cmd.ready_value;
			end
			if (cmd.set_crit) begin
				crit_q[TIW'(cmd.task_id)] <= crit_sat;
			end
		end
	end

	assign lk_ready = lk_ok ? ready_q[TIW'(lk_task)] : 1'b0;
	assign lk_crit  = lk_ok ? crit_q[TIW'(lk_task)] : '0;

endmodule

// ===== design/frame_table_criticality_scheduler.sv =====
// channel | dir | handshake         | payload
// s       | in  | s_tvalid/s_tready | s_tuser: req_type; s_tdata: task_id .. running_criticality
// m       | out | m_tvalid/m_tready | m_tdata: found, chosen_task, can_preempt, idle_kick
//
// slot write, set ready, unpause, set criticality: from accept straight to the done state
// pop and a dequeue of an in-range task scan every slot, the preempt query all but
// one: one slot read per cycle through the slot table read port, then the done state
// s_tready is high only while idle; the result sits in the output register until taken
// a held result stalls completion of the next item, not its acceptance
// arst_n clears the slot valid bits, ready flags, criticalities and pointer at once
module frame_table_criticality_scheduler
	import fts_pkg::*;
#(
	parameter int NUM_SLOTS  = 16,
	parameter int NUM_TASKS  = 16,
	parameter int NUM_LEVELS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [3:0] task_id, [7:4] slot_index, [8] slot_occupied, [9] ready_value,
	// [11:10] new_criticality, [13:12] system_level, [15:14] running_criticality
	input  logic [15:0] s_tdata,
	// [2:0] req_type
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] found, [4:1] chosen_task, [5] can_preempt, [6] idle_kick, [7] zero
	output logic [7:0]  m_tdata
);

	localparam int SIW   = $clog2(NUM_SLOTS);
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);

	// one-hot sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q;

	// unpacked input item
	logic [REQ_W-1:0]  in_req;
	logic [TASK_W-1:0] in_task;
	logic [SLOT_W-1:0] in_slot;
	logic              in_occ;
	logic              in_rdy;
	logic [CRIT_W-1:0] in_ncrit;
	logic [CRIT_W-1:0] in_level;
	logic [CRIT_W-1:0] in_running;

	assign in_req     = s_tuser;
	assign in_task    = s_tdata[3:0];
	assign in_slot    = s_tdata[7:4];
	assign in_occ     = s_tdata[8];
	assign in_rdy     = s_tdata[9];
	assign in_ncrit   = s_tdata[11:10];
	assign in_level   = s_tdata[13:12];
	assign in_running = s_tdata[15:14];

	logic accept;
	logic task_ok;
	logic slot_ok;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign task_ok  = 32'(in_task) < NUM_TASKS;
	assign slot_ok  = 32'(in_slot) < NUM_SLOTS;

	// latched request for the scan
	logic [REQ_W-1:0]  req_q;
	logic [TASK_W-1:0] task_q;
	logic [CRIT_W-1:0] level_q;
	logic [CRIT_W-1:0] running_q;

	// scan control
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] len_q;
	logic [SIW-1:0]   ptr_q;
	logic [SIW:0]     addr_sum;
	logic [SIW-1:0]   issue_addr;
	logic             issue;
	logic             scan_end;
	logic             s1_valid_q;
	logic [SIW-1:0]   addr_s1;

	// slot position = pointer + count, wrapped once
	assign addr_sum   = {1'b0, ptr_q} + (SIW + 1)'(cnt_q);
	assign issue_addr = (32'(addr_sum) >= NUM_SLOTS) ?
		SIW'(addr_sum - (SIW + 1)'(NUM_SLOTS)) : SIW'(addr_sum);
	assign issue      = (state_q == ST_SCAN) && (cnt_q < len_q);
	assign scan_end   = (state_q == ST_SCAN) && (cnt_q == len_q) && !s1_valid_q;

	// slot table and task table
	slot_wr_t          slot_wr;
	logic              clr_en;
	logic              rd_valid;
	logic [TASK_W-1:0] rd_task;
	task_cmd_t         task_cmd;
	logic              lk_ready;
	logic [CRIT_W-1:0] lk_crit;

	assign slot_wr.en       = accept && (in_req == REQ_SLOT_WRITE) && slot_ok && task_ok;
	assign slot_wr.occupied = in_occ;
	assign slot_wr.task_id  = in_task;

	assign task_cmd.set_ready   = accept && ((in_req == REQ_SET_READY) ||
		(in_req == REQ_UNPAUSE));
	assign task_cmd.ready_value = (in_req == REQ_UNPAUSE) ? 1'b1 : in_rdy;
	assign task_cmd.set_crit    = accept && (in_req == REQ_SET_CRIT);
	assign task_cmd.crit        = in_ncrit;
	assign task_cmd.task_id     = in_task;

	fts_slot_mem #(
		.NUM_SLOTS (NUM_SLOTS),
		.SIW       (SIW)
	) u_slot_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (slot_wr),
		.wr_addr  (SIW'(in_slot)),
		.clr_en   (clr_en),
		.clr_addr (addr_s1),
		.rd_en    (issue),
		.rd_addr  (issue_addr),
		.rd_valid (rd_valid),
		.rd_task  (rd_task)
	);

	fts_task_tbl #(
		.NUM_TASKS  (NUM_TASKS),
		.NUM_LEVELS (NUM_LEVELS)
	) u_task_tbl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (task_cmd),
		.lk_task  (rd_task),
		.lk_ready (lk_ready),
		.lk_crit  (lk_crit)
	);

	// shared per-slot evaluation
	logic live;
	logic crit_ge;

	assign live    = s1_valid_q && rd_valid && lk_ready;
	assign crit_ge = lk_crit >= level_q;
	// dequeue empties every valid slot naming the task
	assign clr_en  = s1_valid_q && (req_q == REQ_DEQUEUE) && rd_valid && (rd_task == task_q);

	// scan accumulators
	logic              have_first_q;
	logic [SIW-1:0]    first_idx_q;
	logic [TASK_W-1:0] first_task_q;
	logic              picked_q;
	logic [SIW-1:0]    pick_idx_q;
	logic [TASK_W-1:0] pick_task_q;
	logic              hit_q;

	// pending result
	logic              res_found_q;
	logic [TASK_W-1:0] res_task_q;
	logic              res_preempt_q;
	logic              res_kick_q;

	// output register
	logic              m_tvalid_q;
	logic              out_found_q;
	logic [TASK_W-1:0] out_task_q;
	logic              out_preempt_q;
	logic              out_kick_q;
	logic              out_free;

	assign out_free = !m_tvalid_q || m_tready;

	// pop decision and pointer past the pick
	logic              pop_found;
	logic [SIW-1:0]    pop_idx;
	logic [TASK_W-1:0] pop_task;
	logic [SIW-1:0]    pop_next;

	assign pop_found = picked_q || have_first_q;
	assign pop_idx   = picked_q ? pick_idx_q : first_idx_q;
	assign pop_task  = picked_q ? pick_task_q : first_task_q;
	assign pop_next  = (pop_idx == SIW'(NUM_SLOTS - 1)) ? '0 : pop_idx + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			len_q      <= '0;
			ptr_q      <= '0;
			s1_valid_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			s1_valid_q <= issue;
			// load a finished result, else drop the one just taken
			if ((state_q == ST_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						case (in_req)
							REQ_POP: begin
								len_q   <= CNT_W'(NUM_SLOTS);
								state_q <= ST_SCAN;
							end
							REQ_PREEMPT_Q: begin
								len_q   <= CNT_W'(NUM_SLOTS - 1);
								state_q <= ST_SCAN;
							end
							REQ_DEQUEUE: begin
								len_q   <= CNT_W'(NUM_SLOTS);
								state_q <= task_ok ? ST_SCAN : ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (scan_end) begin
						if ((req_q == REQ_POP) && pop_found) begin
							ptr_q <= pop_next;
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request latch, accumulators and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q         <= in_req;
			task_q        <= in_task;
			level_q       <= in_level;
			running_q     <= in_running;
			have_first_q  <= 1'b0;
			picked_q      <= 1'b0;
			hit_q         <= 1'b0;
			res_found_q   <= 1'b0;
			res_task_q    <= '0;
			res_preempt_q <= 1'b0;
			res_kick_q    <= (in_req == REQ_UNPAUSE);
		end
		addr_s1 <= issue_addr;
		if (live && !have_first_q) begin
			have_first_q <= 1'b1;
			first_idx_q  <= addr_s1;
			first_task_q <= rd_task;
		end
		if (live && crit_ge && !picked_q) begin
			picked_q    <= 1'b1;
			pick_idx_q  <= addr_s1;
			pick_task_q <= rd_task;
		end
		if (live && ((running_q < level_q) || crit_ge)) begin
			hit_q <= 1'b1;
		end
		if (scan_end) begin
			if (req_q == REQ_POP) begin
				res_found_q <= pop_found;
				res_task_q  <= pop_found ? pop_task : '0;
			end
			res_preempt_q <= (req_q == REQ_PREEMPT_Q) && hit_q;
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_found_q   <= res_found_q;
			out_task_q    <= res_task_q;
			out_preempt_q <= res_preempt_q;
			out_kick_q    <= res_kick_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, out_kick_q, out_preempt_q, out_task_q, out_found_q};

	// pointer stays inside the slot table
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ptr_q) < NUM_SLOTS)
		else $error("rotate pointer out of range");

	// a result with nothing found reports task zero
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && !out_found_q |-> out_task_q == '0)
		else $error("chosen task without a find");

	// at most one kind of result flag per item
	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> $onehot0({out_found_q, out_preempt_q, out_kick_q}))
		else $error("conflicting result flags");

	// the scan never reads past its length
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> cnt_q <= len_q)
		else $error("scan count past length");

	// an accepted item closes the input until its result is produced
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("second item taken during work");

endmodule

// ===== tb/tb_frame_table_criticality_scheduler.sv =====
module tb_frame_table_criticality_scheduler;
	import fts_pkg::*;

	localparam int N_SLOTS      = 16;
	localparam int N_TASKS      = 16;
	localparam int N_LEVELS     = 4;
	localparam int RANDOM_ITEMS = 400;
	localparam int LONG_HOLD    = 400;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 200000;

	// req_type 7 has no package name, the block must answer it with all zeros
	localparam logic [REQ_W-1:0] REQ_UNKNOWN = 3'd7;

	// one request item as the sender sees it, plus its pacing
	typedef struct {
		logic [REQ_W-1:0]  req;
		logic [TASK_W-1:0] task_id;
		logic [SLOT_W-1:0] slot;
		logic              occ;
		logic              rdy;
		logic [CRIT_W-1:0] ncrit;
		logic [CRIT_W-1:0] level;
		logic [CRIT_W-1:0] running;
		int                gap;          // cycles to wait before offering
		bit                drain_first;  // hold the item until all results are back
	} sched_req_t;

	// one scheduling decision as it comes out of m_tdata
	typedef struct {
		logic              found;
		logic [TASK_W-1:0] chosen;
		logic              preempt;
		logic              kick;
	} sched_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;

	frame_table_criticality_scheduler #(
		.NUM_SLOTS (N_SLOTS),
		.NUM_TASKS (N_TASKS),
		.NUM_LEVELS(N_LEVELS)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #4 clk = ~clk;

	// shadow copy of the scheduler tables, all at their reset values
	logic [TASK_W-1:0] frame_task [N_SLOTS];
	bit                frame_used [N_SLOTS];
	bit                task_is_ready [N_TASKS];
	logic [CRIT_W-1:0] task_crit [N_TASKS];
	logic [SLOT_W-1:0] scan_start = '0;

	initial begin
		for (int k = 0; k < N_SLOTS; k++) begin
			frame_task[k] = '0;
			frame_used[k] = 1'b0;
		end
		for (int k = 0; k < N_TASKS; k++) begin
			task_is_ready[k] = 1'b0;
			task_crit[k] = '0;
		end
	end

	sched_req_t pending_reqs[$];     // items waiting for the driver
	sched_res_t expected_results[$]; // decisions owed by the block, oldest first
	sched_req_t cur_req;
	int         issued_count = 0;
	int         rcvd_count = 0;
	int         gap_count = 0;
	int         stall_left = 0;
	int         cycle_count = 0;
	bit         failed = 1'b0;

	// slot s names a task that is ready to run
	function automatic bit frame_live(logic [SLOT_W-1:0] s);
		return frame_used[s] && frame_task[s] < N_TASKS && task_is_ready[frame_task[s]];
	endfunction

	// apply one request to the shadow tables and return the decision it yields
	function automatic sched_res_t schedule_step(sched_req_t r);
		sched_res_t        res;
		bit                task_ok;
		bit                have_first;
		bit                picked;
		logic [SLOT_W-1:0] s;
		logic [SLOT_W-1:0] first_slot;
		logic [SLOT_W-1:0] pick_slot;
		logic [CRIT_W-1:0] nc;
		res = '{found: 1'b0, chosen: '0, preempt: 1'b0, kick: 1'b0};
		task_ok = r.task_id < N_TASKS;
		have_first = 1'b0;
		picked = 1'b0;
		first_slot = '0;
		pick_slot = '0;
		case (r.req)
			REQ_SLOT_WRITE: begin
				if (r.slot < N_SLOTS && task_ok) begin
					frame_used[r.slot] = r.occ;
					frame_task[r.slot] = r.occ ? r.task_id : '0;
				end
			end
			REQ_SET_READY: begin
				if (task_ok)
					task_is_ready[r.task_id] = r.rdy;
			end
			REQ_UNPAUSE: begin
				// the kick goes out even for a task the table does not hold
				if (task_ok)
					task_is_ready[r.task_id] = 1'b1;
				res.kick = 1'b1;
			end
			REQ_SET_CRIT: begin
				if (task_ok) begin
					nc = (r.ncrit >= N_LEVELS) ? CRIT_W'(N_LEVELS - 1) : r.ncrit;
					task_crit[r.task_id] = nc;
				end
			end
			REQ_DEQUEUE: begin
				if (task_ok) begin
					for (int i = 0; i < N_SLOTS; i++) begin
						if (frame_used[i] && frame_task[i] == r.task_id) begin
							frame_used[i] = 1'b0;
							frame_task[i] = '0;
						end
					end
				end
			end
			REQ_POP: begin
				// first ready task at or above the level wins, else first ready task
				for (int i = 0; i < N_SLOTS && !picked; i++) begin
					s = scan_start + SLOT_W'(i);
					if (frame_live(s)) begin
						if (!have_first) begin
							have_first = 1'b1;
							first_slot = s;
						end
						if (task_crit[frame_task[s]] >= r.level) begin
							picked = 1'b1;
							pick_slot = s;
						end
					end
				end
				if (!picked && have_first) begin
					picked = 1'b1;
					pick_slot = first_slot;
				end
				if (picked) begin
					res.found = 1'b1;
					res.chosen = frame_task[pick_slot];
					scan_start = pick_slot + 1'b1;  // wraps past the last slot
				end
			end
			REQ_PREEMPT_Q: begin
				// the slot just behind the pointer is not looked at
				for (int i = 0; i + 1 < N_SLOTS && !res.preempt; i++) begin
					s = scan_start + SLOT_W'(i);
					if (frame_live(s) &&
							(r.running < r.level || task_crit[frame_task[s]] >= r.level))
						res.preempt = 1'b1;
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	task automatic add_directed(input logic [REQ_W-1:0] req, input logic [TASK_W-1:0] tid,
			input logic [SLOT_W-1:0] sl, input logic occ, input logic rdy,
			input logic [CRIT_W-1:0] nc, input logic [CRIT_W-1:0] lv,
			input logic [CRIT_W-1:0] rc);
		sched_req_t r;
		r = '{req: req, task_id: tid, slot: sl, occ: occ, rdy: rdy, ncrit: nc, level: lv,
			running: rc, gap: $urandom_range(0, 19), drain_first: 1'b0};
		pending_reqs.push_back(r);
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failed = 1'b1;
		end
	endtask

	// driver: offers the next pending item once its gap has run out
	always @(posedge clk or negedge arst_n) begin : drive_proc
		bit offer;
		bit accepted;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap_count <= 0;
		end else begin
			offer = s_tvalid;
			accepted = s_tvalid && s_tready;
			if (accepted) begin
				expected_results.push_back(schedule_step(cur_req));
				issued_count <= issued_count + 1;
				offer = 1'b0;
			end
			if (!offer && pending_reqs.size() > 0) begin
				if (gap_count < pending_reqs[0].gap) begin
					gap_count <= gap_count + 1;
				end else if (!pending_reqs[0].drain_first ||
						issued_count + int'(accepted) == rcvd_count) begin
					// a drain item waits until every owed decision is back
					cur_req = pending_reqs.pop_front();
					s_tdata <= {cur_req.running, cur_req.level, cur_req.ncrit, cur_req.rdy,
						cur_req.occ, cur_req.slot, cur_req.task_id};
					s_tuser <= cur_req.req;
					gap_count <= 0;
					offer = 1'b1;
				end
			end
			s_tvalid <= offer;
		end
	end

	// monitor: checks each decision and paces m_tready per item
	always @(posedge clk or negedge arst_n) begin : check_proc
		sched_res_t want;
		int         n;
		int         w;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else if (m_tvalid && m_tready) begin
			n = rcvd_count + 1;
			rcvd_count <= n;
			if (expected_results.size() == 0) begin
				$error("unexpected item on m_tdata: %h", m_tdata);
				failed = 1'b1;
			end else begin
				want = expected_results.pop_front();
				check_field("found", 32'(want.found), 32'(m_tdata[0]));
				check_field("chosen_task", 32'(want.chosen), 32'(m_tdata[4:1]));
				check_field("can_preempt", 32'(want.preempt), 32'(m_tdata[5]));
				check_field("idle_kick", 32'(want.kick), 32'(m_tdata[6]));
				check_field("reserved", 0, 32'(m_tdata[7]));
			end
			// two long hold-offs back up the block; some stretches never stall
			if (n == 40 || n == 260)
				w = LONG_HOLD;
			else if ((n / 50) % 4 == 1)
				w = 0;
			else
				w = $urandom_range(0, 19);
			m_tready <= (w == 0);
			stall_left <= w;
		end else if (!m_tready) begin
			if (stall_left <= 1) begin
				m_tready <= 1'b1;
				stall_left <= 0;
			end else begin
				stall_left <= stall_left - 1;
			end
		end
	end

	// hang guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("frame_table_criticality_scheduler regression: fail");
			$finish;
		end
	end

	initial begin
		sched_req_t r;
		int         i;
		int         pick;
		int         total;

		// directed: empty table, unknown request, then a small table worked by hand
		add_directed(REQ_POP, 4'd0, 4'd0, 1'b0, 1'b0, 2'd0, 2'd0, 2'd0);
		add_directed(REQ_PREEMPT_Q, 4'd0, 4'd0, 1'b0, 1'b0, 2'd0, 2'd3, 2'd0);
		add_directed(REQ_UNKNOWN, 4'd15, 4'd15, 1'b1, 1'b1, 2'd3, 2'd3, 2'd3);
		add_directed(REQ_SLOT_WRITE, 4'd15, 4'd0, 1'b1, 1'b0, 2'd0, 2'd0, 2'd0);
		add_directed(REQ_SLOT_WRITE, 4'd0, 4'd15, 1'b1, 1'b1, 2'd3, 2'd3, 2'd3);
		add_directed(REQ_SLOT_WRITE, 4'd9, 4'd7, 1'b1, 1'b0, 2'd1, 2'd2, 2'd1);
		add_directed(REQ_SET_READY, 4'd15, 4'd3, 1'b0, 1'b1, 2'd0, 2'd0, 2'd0);
		add_directed(REQ_UNPAUSE, 4'd0, 4'd0, 1'b0, 1'b0, 2'd0, 2'd0, 2'd0);
		add_directed(REQ_SET_READY, 4'd9, 4'd12, 1'b1, 1'b1, 2'd2, 2'd1, 2'd2);
		add_directed(REQ_SET_CRIT, 4'd15, 4'd0, 1'b0, 1'b0, 2'd3, 2'd0, 2'd0);
		add_directed(REQ_SET_CRIT, 4'd9, 4'd5, 1'b1, 1'b0, 2'd2, 2'd1, 2'd3);
		add_directed(REQ_SET_CRIT, 4'd0, 4'd0, 1'b0, 1'b1, 2'd1, 2'd0, 2'd0);
		// running task at the top level, only a level-3 task can preempt it
		add_directed(REQ_PREEMPT_Q, 4'd3, 4'd8, 1'b0, 1'b0, 2'd0, 2'd3, 2'd3);
		add_directed(REQ_POP, 4'd0, 4'd0, 1'b0, 1'b0, 2'd0, 2'd3, 2'd0);
		add_directed(REQ_POP, 4'd0, 4'd0, 1'b0, 1'b0, 2'd0, 2'd2, 2'd0);
		// nothing at the level before the wrap, the pick lies past it in slot 0
		add_directed(REQ_POP, 4'd0, 4'd0, 1'b0, 1'b0, 2'd0, 2'd3, 2'd0);
		add_directed(REQ_POP, 4'd0, 4'd0, 1'b0, 1'b0, 2'd0, 2'd0, 2'd0);
		// pick in the last slot, pointer wraps to slot 0
		add_directed(REQ_POP, 4'd0, 4'd0, 1'b0, 1'b0, 2'd0, 2'd0, 2'd0);
		add_directed(REQ_PREEMPT_Q, 4'd0, 4'd0, 1'b0, 1'b0, 2'd0, 2'd3, 2'd2);
		add_directed(REQ_SET_READY, 4'd15, 4'd0, 1'b0, 1'b0, 2'd0, 2'd0, 2'd0);
		// qualifying tasks sit in slot 7 and in the unscanned last slot
		add_directed(REQ_PREEMPT_Q, 4'd0, 4'd0, 1'b0, 1'b0, 2'd0, 2'd1, 2'd3);
		add_directed(REQ_SLOT_WRITE, 4'd9, 4'd7, 1'b0, 1'b0, 2'd0, 2'd0, 2'd0);
		add_directed(REQ_DEQUEUE, 4'd0, 4'd0, 1'b0, 1'b0, 2'd0, 2'd0, 2'd0);
		add_directed(REQ_POP, 4'd0, 4'd0, 1'b0, 1'b0, 2'd0, 2'd1, 2'd0);

		// random: table fills mostly, pops and queries dominate
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 20)
				r.req = REQ_SLOT_WRITE;
			else if (pick < 35)
				r.req = REQ_SET_READY;
			else if (pick < 45)
				r.req = REQ_UNPAUSE;
			else if (pick < 55)
				r.req = REQ_SET_CRIT;
			else if (pick < 60)
				r.req = REQ_DEQUEUE;
			else if (pick < 85)
				r.req = REQ_POP;
			else if (pick < 97)
				r.req = REQ_PREEMPT_Q;
			else
				r.req = REQ_UNKNOWN;
			r.task_id = TASK_W'($urandom_range(0, 15));
			r.slot = SLOT_W'($urandom_range(0, 15));
			r.occ = ($urandom_range(0, 4) != 0);
			r.rdy = ($urandom_range(0, 9) < 7);
			r.ncrit = CRIT_W'($urandom_range(0, 3));
			r.level = CRIT_W'($urandom_range(0, 3));
			r.running = CRIT_W'($urandom_range(0, 3));
			r.gap = ((i / 40) % 3 == 2) ? 0 : $urandom_range(0, 19);
			r.drain_first = (i == 120 || i == 280);
			pending_reqs.push_back(r);
		end
		total = pending_reqs.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// every item owes one decision
		while (rcvd_count != total)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d decisions never came out", expected_results.size());
			failed = 1'b1;
		end
		if (!failed)
			$display("frame_table_criticality_scheduler regression: pass");
		else
			$display("frame_table_criticality_scheduler regression: fail");
		$finish;
	end

endmodule
